/* rtl/hysteresis_relay_with_min_dwell_assert.svh */
// Assertion macros used by the hysteresis relay RTL.
// Depends on nothing; included by hrmd_core, the module that carries assertions.
`ifndef HYSTERESIS_RELAY_WITH_MIN_DWELL_ASSERT_SVH
`define HYSTERESIS_RELAY_WITH_MIN_DWELL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HRMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hysteresis relay assertion failed");

// Next-cycle implication, checked outside reset.
`define HRMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hysteresis relay assertion failed");

`endif

/* rtl/hrmd_pkg.sv */
// Package for the hysteresis relay: event and register codes, shared structs
// and the level clamp. Depends on nothing.
`default_nettype none

package hrmd_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 32;
  localparam int LEVEL_BITS     = 17;
  localparam int OUT_BITS       = 32;

  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = 17'h10000;

  typedef enum logic [1:0] {
    FUNC_PROPOSE = 2'd0,
    FUNC_COMMIT  = 2'd1,
    FUNC_SYNC    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OVR_NONE = 2'd0,
    OVR_ON   = 2'd1,
    OVR_OFF  = 2'd2
  } ovr_t;

  typedef enum logic [1:0] {
    REG_ON_LEVEL  = 2'd0,
    REG_OFF_LEVEL = 2'd1,
    REG_MIN_ON    = 2'd2,
    REG_MIN_OFF   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] on_level;
    logic [LEVEL_BITS-1:0] off_level;
    logic [31:0]           min_on_time;
    logic [31:0]           min_off_time;
  } cfg_t;

  typedef struct packed {
    func_t        func;
    logic [17:0]  request_level;
    logic         request_invalid;
    logic [1:0]   override_sel;
    logic         want_on;
    logic         cmd_needed;
    logic         was_held;
    logic [31:0]  generation_tag;
    logic         cmd_done;
  } evt_t;

  typedef struct packed {
    logic                target_is_on;
    logic                dwell_bypassed;
    logic                override_used;
    logic                dwell_hold;
    logic                command_needed;
    logic [OUT_BITS-1:0] current_generation;
    logic                accepted;
    logic [OUT_BITS-1:0] overrides_seen;
    logic [OUT_BITS-1:0] holds_seen;
    logic [OUT_BITS-1:0] transitions_seen;
    logic                state_known;
    logic                state_is_on;
  } res_t;

  function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
    clamp_level = (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/hrmd_cfg.sv */
// Configuration register file of the hysteresis relay: thresholds and dwell times.
// Depends on hrmd_pkg.
`default_nettype none

module hrmd_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_addr,
  input  wire logic [31:0]          cfg_wdata,
  output hrmd_pkg::cfg_t            cfg
);

  hrmd_pkg::cfg_t cfg_r;
  hrmd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hrmd_pkg::reg_idx_t'(cfg_addr))
        hrmd_pkg::REG_ON_LEVEL:  cfg_nxt.on_level     = cfg_wdata[hrmd_pkg::LEVEL_BITS-1:0];
        hrmd_pkg::REG_OFF_LEVEL: cfg_nxt.off_level    = cfg_wdata[hrmd_pkg::LEVEL_BITS-1:0];
        hrmd_pkg::REG_MIN_ON:    cfg_nxt.min_on_time  = cfg_wdata;
        hrmd_pkg::REG_MIN_OFF:   cfg_nxt.min_off_time = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/hrmd_core.sv */
// Decision logic and relay state of the hysteresis relay: hysteresis, dwell check,
// commit and synchronize handling, counters. Depends on hrmd_pkg and the assert header.
`default_nettype none
`include "hysteresis_relay_with_min_dwell_assert.svh"

module hrmd_core #(
  parameter int TIME_BITS  = hrmd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = hrmd_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire hrmd_pkg::evt_t       evt,
  input  wire logic [TIME_BITS-1:0] evt_time,
  input  wire hrmd_pkg::cfg_t       cfg,
  output hrmd_pkg::res_t            res
);

  logic                  known_r, known_nxt;
  logic                  on_r, on_nxt;
  logic [TIME_BITS-1:0]  last_r, last_nxt;
  logic [COUNT_BITS-1:0] gen_r, gen_nxt;
  logic [COUNT_BITS-1:0] ovr_cnt_r, ovr_cnt_nxt;
  logic [COUNT_BITS-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [COUNT_BITS-1:0] trans_cnt_r, trans_cnt_nxt;

  logic [hrmd_pkg::LEVEL_BITS-1:0] lvl;
  logic [hrmd_pkg::LEVEL_BITS-1:0] on_t;
  logic [hrmd_pkg::LEVEL_BITS-1:0] off_c;
  logic [hrmd_pkg::LEVEL_BITS-1:0] off_t;
  logic [TIME_BITS:0]              diff;
  logic [TIME_BITS-1:0]            elapsed;
  logic [31:0]                     need;
  logic                            dwell_short;
  logic                            tag_match;

  always_comb begin
    lvl = (evt.request_invalid || evt.request_level[17]) ? '0 :
          hrmd_pkg::clamp_level(evt.request_level[hrmd_pkg::LEVEL_BITS-1:0]);
    on_t  = hrmd_pkg::clamp_level(cfg.on_level);
    off_c = hrmd_pkg::clamp_level(cfg.off_level);
    off_t = (off_c > on_t) ? on_t : off_c;
    diff    = {1'b0, evt_time} - {1'b0, last_r};
    elapsed = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
    need    = on_r ? cfg.min_on_time : cfg.min_off_time;
    dwell_short = elapsed < TIME_BITS'(need);
    tag_match   = 64'(evt.generation_tag) == 64'(gen_r);
  end

  always_comb begin
    known_nxt     = known_r;
    on_nxt        = on_r;
    last_nxt      = last_r;
    gen_nxt       = gen_r;
    ovr_cnt_nxt   = ovr_cnt_r;
    hold_cnt_nxt  = hold_cnt_r;
    trans_cnt_nxt = trans_cnt_r;
    res           = '0;

    unique case (evt.func)
      hrmd_pkg::FUNC_PROPOSE: begin
        unique case (hrmd_pkg::ovr_t'(evt.override_sel))
          hrmd_pkg::OVR_ON: begin
            res.target_is_on   = 1'b1;
            res.dwell_bypassed = 1'b1;
            res.override_used  = !known_r || !on_r;
          end
          hrmd_pkg::OVR_OFF: begin
            res.target_is_on   = 1'b0;
            res.dwell_bypassed = 1'b1;
            res.override_used  = !known_r || on_r;
          end
          default: begin
            res.target_is_on = (known_r && on_r) ? (lvl > off_t) : (lvl >= on_t);
          end
        endcase
        if (res.override_used) begin
          ovr_cnt_nxt = ovr_cnt_r + COUNT_BITS'(1);
        end
        if (!(known_r && (res.target_is_on == on_r))) begin
          if (known_r && !res.dwell_bypassed && dwell_short) begin
            res.dwell_hold = 1'b1;
            hold_cnt_nxt   = hold_cnt_r + COUNT_BITS'(1);
          end else begin
            res.command_needed = 1'b1;
          end
        end
      end
      hrmd_pkg::FUNC_COMMIT: begin
        if (evt.cmd_needed && !evt.was_held && tag_match) begin
          res.accepted = 1'b1;
          if (evt.cmd_done) begin
            if (!known_r || (on_r != evt.want_on)) begin
              trans_cnt_nxt = trans_cnt_r + COUNT_BITS'(1);
            end
            known_nxt = 1'b1;
            on_nxt    = evt.want_on;
            last_nxt  = evt_time;
            gen_nxt   = gen_r + COUNT_BITS'(1);
          end
        end
      end
      hrmd_pkg::FUNC_SYNC: begin
        known_nxt = 1'b1;
        on_nxt    = evt.want_on;
        last_nxt  = evt_time;
        gen_nxt   = gen_r + COUNT_BITS'(1);
      end
      default: begin
        res = '0;
      end
    endcase

    res.current_generation = 32'(64'(gen_nxt));
    res.overrides_seen     = 32'(64'(ovr_cnt_nxt));
    res.holds_seen         = 32'(64'(hold_cnt_nxt));
    res.transitions_seen   = 32'(64'(trans_cnt_nxt));
    res.state_known        = known_nxt;
    res.state_is_on        = on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r     <= 1'b0;
      on_r        <= 1'b0;
      last_r      <= '0;
      gen_r       <= '0;
      ovr_cnt_r   <= '0;
      hold_cnt_r  <= '0;
      trans_cnt_r <= '0;
    end else if (fire) begin
      known_r     <= known_nxt;
      on_r        <= on_nxt;
      last_r      <= last_nxt;
      gen_r       <= gen_nxt;
      ovr_cnt_r   <= ovr_cnt_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      trans_cnt_r <= trans_cnt_nxt;
    end
  end

  `HRMD_ASSERT_NEXT(a_gen_still_when_idle, clk, rst_n, !fire, $stable(gen_r))
  `HRMD_ASSERT_NOW(a_hold_excludes_cmd, clk, rst_n, fire, !(res.dwell_hold && res.command_needed))
  `HRMD_ASSERT_NOW(a_accept_only_on_commit, clk, rst_n, res.accepted,
                   evt.func == hrmd_pkg::FUNC_COMMIT)
  `HRMD_ASSERT_NEXT(a_commit_done_latches, clk, rst_n,
                    fire && res.accepted && evt.cmd_done, known_r && (on_r == $past(evt.want_on)))

endmodule

`default_nettype wire

/* rtl/hysteresis_relay_with_min_dwell.sv */
// Top level of the hysteresis relay with minimum dwell: stream ports, input and
// result registers. Depends on hrmd_pkg, hrmd_cfg and hrmd_core.
//
// Each input beat is one event (propose, commit or synchronize, selected by
// in_tuser) and yields exactly one result beat. While the result side is ready,
// the block takes one beat per clock with no bubbles. A result beat is offered
// once its beat has passed the input and result registers; the decision, dwell
// subtract and compare, and counter update are done combinationally from the
// input register before the result register takes the outcome. Back-pressure on
// the result side holds the result register in place and stalls the input
// once the input register is also full, and the relay state advances only
// when an event moves into the result register, so the next event always sees
// the state its predecessor left. Configuration writes take effect on the next
// clock and should be made only while no events are in flight.
`default_nettype none

module hysteresis_relay_with_min_dwell #(
  parameter int TIME_BITS  = hrmd_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = hrmd_pkg::COUNT_BITS_DEF,
  localparam int IN_USED   = 57 + TIME_BITS,
  localparam int IN_W      = ((IN_USED + 7) / 8) * 8,
  localparam int OUT_W     = 136
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request_level, request_invalid, override_sel, time_ms, want_on, cmd_needed,
  // was_held, generation_tag, cmd_done, zero padding
  input  wire logic [IN_W-1:0]   in_tdata,
  // func
  input  wire logic [1:0]        in_tuser,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // target_is_on, dwell_bypassed, override_used, dwell_hold, command_needed,
  // current_generation, accepted, overrides_seen, holds_seen, transitions_seen,
  // state_known, state_is_on
  output logic [OUT_W-1:0]       out_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [31:0]       cfg_wdata
);

  localparam int TO = 21 + TIME_BITS;

  hrmd_pkg::cfg_t        cfg;
  hrmd_pkg::evt_t        evt_r, evt_nxt;
  logic [TIME_BITS-1:0]  time_r;
  logic                  s1_v_r, s1_v_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [OUT_W-1:0]      out_d_r;
  hrmd_pkg::res_t        res;
  logic                  adv;
  logic                  fire;
  logic                  take;

  assign adv       = !out_v_r || out_tready;
  assign fire      = s1_v_r && adv;
  assign in_tready = !s1_v_r || adv;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    evt_nxt.func            = hrmd_pkg::func_t'(in_tuser);
    evt_nxt.request_level   = in_tdata[17:0];
    evt_nxt.request_invalid = in_tdata[18];
    evt_nxt.override_sel    = in_tdata[20:19];
    evt_nxt.want_on         = in_tdata[TO];
    evt_nxt.cmd_needed      = in_tdata[TO+1];
    evt_nxt.was_held        = in_tdata[TO+2];
    evt_nxt.generation_tag  = in_tdata[TO+3 +: 32];
    evt_nxt.cmd_done        = in_tdata[TO+35];
    s1_v_nxt  = take ? 1'b1 : (fire ? 1'b0 : s1_v_r);
    out_v_nxt = fire ? 1'b1 : (adv ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      evt_r  <= evt_nxt;
      time_r <= in_tdata[21 +: TIME_BITS];
    end
    if (fire) begin
      out_d_r <= {res.state_is_on, res.state_known, res.transitions_seen,
                  res.holds_seen, res.overrides_seen, res.accepted,
                  res.current_generation, res.command_needed, res.dwell_hold,
                  res.override_used, res.dwell_bypassed, res.target_is_on};
    end
  end

  hrmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hrmd_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .evt      (evt_r),
    .evt_time (time_r),
    .cfg      (cfg),
    .res      (res)
  );

  assign out_tdata  = out_d_r;
  assign out_tvalid = out_v_r;

endmodule

`default_nettype wire

/* verif/tb_hysteresis_relay_with_min_dwell.sv */
// Self-checking testbench for the hysteresis relay with minimum dwell times.
// Drives propose, commit and synchronize beats through the stream ports, predicts every
// result in-line and compares it field by field. Depends on hrmd_pkg and the RTL top level.
module tb_hysteresis_relay_with_min_dwell;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = 112;
  localparam int OUT_W = 136;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;
  localparam logic [1:0] OVR_UNDEF = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [17:0] level;
    logic        invalid;
    logic [1:0]  ovr;
    logic [47:0] time_ms;
    logic        want_on;
    logic        cmd_needed;
    logic        was_held;
    logic [31:0] tag;
    logic        cmd_done;
  } relay_evt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // Shadow of the relay configuration and state.
  logic [16:0] cfg_on_lvl = '0;
  logic [16:0] cfg_off_lvl = '0;
  logic [31:0] cfg_min_on = '0;
  logic [31:0] cfg_min_off = '0;
  logic relay_known = 1'b0;
  logic relay_on = 1'b0;
  logic [47:0] last_change_ms = '0;
  logic [31:0] gen_cnt = '0;
  logic [31:0] ovr_cnt = '0;
  logic [31:0] hold_cnt = '0;
  logic [31:0] trans_cnt = '0;

  hrmd_pkg::res_t pending_results[$];

  logic tx_mode = 1'b1;
  logic rx_mode = 1'b1;
  logic out_hold = 1'b0;
  int unsigned rx_stall_left = 0;
  logic [47:0] now_ms = 48'd0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned n_propose = 0;
  int unsigned n_commit = 0;
  int unsigned n_sync = 0;
  int unsigned n_undef = 0;
  int unsigned n_hold = 0;
  int unsigned n_accept = 0;
  int unsigned n_settings = 0;

  hysteresis_relay_with_min_dwell u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("FAIL hysteresis_relay_with_min_dwell");
      $finish;
    end
  end

  function automatic int unsigned pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (out_hold) begin
      out_tready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      out_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_mode && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      rx_stall_left <= pick_span() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void eff_levels(output logic [16:0] on_t, output logic [16:0] off_t);
    on_t = (cfg_on_lvl > hrmd_pkg::LEVEL_ONE) ? hrmd_pkg::LEVEL_ONE : cfg_on_lvl;
    off_t = (cfg_off_lvl > hrmd_pkg::LEVEL_ONE) ? hrmd_pkg::LEVEL_ONE : cfg_off_lvl;
    if (off_t > on_t) off_t = on_t;
  endfunction

  function automatic hrmd_pkg::res_t relay_decide(relay_evt_t ev);
    hrmd_pkg::res_t r;
    logic [16:0] lvl;
    logic [16:0] on_t;
    logic [16:0] off_t;
    logic [47:0] elapsed;
    logic [31:0] need;
    r = '0;
    if (ev.func == hrmd_pkg::FUNC_PROPOSE) begin
      if (ev.invalid || ev.level[17]) lvl = '0;
      else lvl = (ev.level[16:0] > hrmd_pkg::LEVEL_ONE) ? hrmd_pkg::LEVEL_ONE : ev.level[16:0];
      eff_levels(on_t, off_t);
      if (ev.ovr == hrmd_pkg::OVR_ON) begin
        r.target_is_on = 1'b1;
        r.dwell_bypassed = 1'b1;
        r.override_used = !relay_known || !relay_on;
      end else if (ev.ovr == hrmd_pkg::OVR_OFF) begin
        r.target_is_on = 1'b0;
        r.dwell_bypassed = 1'b1;
        r.override_used = !relay_known || relay_on;
      end else if (relay_known && relay_on) begin
        r.target_is_on = lvl > off_t;
      end else begin
        r.target_is_on = lvl >= on_t;
      end
      if (r.override_used) ovr_cnt = ovr_cnt + 32'd1;
      if (!(relay_known && r.target_is_on == relay_on)) begin
        if (relay_known && !r.dwell_bypassed) begin
          elapsed = (ev.time_ms >= last_change_ms) ? ev.time_ms - last_change_ms : '0;
          need = relay_on ? cfg_min_on : cfg_min_off;
          if (elapsed < {16'b0, need}) begin
            r.dwell_hold = 1'b1;
            hold_cnt = hold_cnt + 32'd1;
          end
        end
        r.command_needed = !r.dwell_hold;
      end
    end else if (ev.func == hrmd_pkg::FUNC_COMMIT) begin
      if (ev.cmd_needed && !ev.was_held && ev.tag == gen_cnt) begin
        r.accepted = 1'b1;
        if (ev.cmd_done) begin
          if (!relay_known || relay_on != ev.want_on) trans_cnt = trans_cnt + 32'd1;
          relay_known = 1'b1;
          relay_on = ev.want_on;
          last_change_ms = ev.time_ms;
          gen_cnt = gen_cnt + 32'd1;
        end
      end
    end else if (ev.func == hrmd_pkg::FUNC_SYNC) begin
      relay_known = 1'b1;
      relay_on = ev.want_on;
      last_change_ms = ev.time_ms;
      gen_cnt = gen_cnt + 32'd1;
    end
    r.current_generation = gen_cnt;
    r.overrides_seen = ovr_cnt;
    r.holds_seen = hold_cnt;
    r.transitions_seen = trans_cnt;
    r.state_known = relay_known;
    r.state_is_on = relay_on;
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [63:0] exp_v, logic [63:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("Mismatch in result %0d, %s: expected %0h, got %0h",
               results_checked, field, exp_v, got_v);
  endtask

  task automatic check_result(hrmd_pkg::res_t e, hrmd_pkg::res_t g);
    if (g.target_is_on !== e.target_is_on)
      note_mismatch("target_is_on", e.target_is_on, g.target_is_on);
    if (g.dwell_bypassed !== e.dwell_bypassed)
      note_mismatch("dwell_bypassed", e.dwell_bypassed, g.dwell_bypassed);
    if (g.override_used !== e.override_used)
      note_mismatch("override_used", e.override_used, g.override_used);
    if (g.dwell_hold !== e.dwell_hold)
      note_mismatch("dwell_hold", e.dwell_hold, g.dwell_hold);
    if (g.command_needed !== e.command_needed)
      note_mismatch("command_needed", e.command_needed, g.command_needed);
    if (g.current_generation !== e.current_generation)
      note_mismatch("current_generation", e.current_generation, g.current_generation);
    if (g.accepted !== e.accepted)
      note_mismatch("accepted", e.accepted, g.accepted);
    if (g.overrides_seen !== e.overrides_seen)
      note_mismatch("overrides_seen", e.overrides_seen, g.overrides_seen);
    if (g.holds_seen !== e.holds_seen)
      note_mismatch("holds_seen", e.holds_seen, g.holds_seen);
    if (g.transitions_seen !== e.transitions_seen)
      note_mismatch("transitions_seen", e.transitions_seen, g.transitions_seen);
    if (g.state_known !== e.state_known)
      note_mismatch("state_known", e.state_known, g.state_known);
    if (g.state_is_on !== e.state_is_on)
      note_mismatch("state_is_on", e.state_is_on, g.state_is_on);
  endtask

  always @(posedge clk) begin : result_monitor
    hrmd_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.target_is_on = out_tdata[0];
      got.dwell_bypassed = out_tdata[1];
      got.override_used = out_tdata[2];
      got.dwell_hold = out_tdata[3];
      got.command_needed = out_tdata[4];
      got.current_generation = out_tdata[36:5];
      got.accepted = out_tdata[37];
      got.overrides_seen = out_tdata[69:38];
      got.holds_seen = out_tdata[101:70];
      got.transitions_seen = out_tdata[133:102];
      got.state_known = out_tdata[134];
      got.state_is_on = out_tdata[135];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Result beat arrived with nothing expected.");
      end else begin
        check_result(pending_results.pop_front(), got);
      end
      results_checked++;
    end
  end

  function automatic relay_evt_t rand_evt();
    relay_evt_t ev;
    ev.func = 2'($urandom);
    ev.level = 18'($urandom);
    ev.invalid = 1'($urandom);
    ev.ovr = 2'($urandom);
    ev.time_ms = {16'($urandom), $urandom()};
    ev.want_on = 1'($urandom);
    ev.cmd_needed = 1'($urandom);
    ev.was_held = 1'($urandom);
    ev.tag = $urandom();
    ev.cmd_done = 1'($urandom);
    return ev;
  endfunction

  task automatic send_item(input relay_evt_t ev, output hrmd_pkg::res_t pr);
    int unsigned gap;
    gap = (tx_mode && $urandom_range(0, 99) < 30) ? pick_span() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= ev.func;
    in_tdata <= {7'b0, ev.cmd_done, ev.tag, ev.was_held, ev.cmd_needed, ev.want_on,
                 ev.time_ms, ev.ovr, ev.invalid, ev.level};
    do @(posedge clk); while (!in_tready);
    pr = relay_decide(ev);
    pending_results.push_back(pr);
    items_sent++;
    case (ev.func)
      hrmd_pkg::FUNC_PROPOSE: n_propose++;
      hrmd_pkg::FUNC_COMMIT: n_commit++;
      hrmd_pkg::FUNC_SYNC: n_sync++;
      default: n_undef++;
    endcase
    if (pr.dwell_hold) n_hold++;
    if (pr.accepted) n_accept++;
  endtask

  task automatic do_propose(logic [17:0] lvl, logic inv, logic [1:0] ovr, logic [47:0] t,
                            output hrmd_pkg::res_t pr);
    relay_evt_t ev;
    ev = rand_evt();
    ev.func = hrmd_pkg::FUNC_PROPOSE;
    ev.level = lvl;
    ev.invalid = inv;
    ev.ovr = ovr;
    ev.time_ms = t;
    send_item(ev, pr);
  endtask

  task automatic do_commit(logic want, logic needed, logic held, logic [31:0] tag,
                           logic [47:0] t, logic done);
    relay_evt_t ev;
    hrmd_pkg::res_t pr;
    ev = rand_evt();
    ev.func = hrmd_pkg::FUNC_COMMIT;
    ev.want_on = want;
    ev.cmd_needed = needed;
    ev.was_held = held;
    ev.tag = tag;
    ev.time_ms = t;
    ev.cmd_done = done;
    send_item(ev, pr);
  endtask

  task automatic do_sync(logic want, logic [47:0] t);
    relay_evt_t ev;
    hrmd_pkg::res_t pr;
    ev = rand_evt();
    ev.func = hrmd_pkg::FUNC_SYNC;
    ev.want_on = want;
    ev.time_ms = t;
    send_item(ev, pr);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(hrmd_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      hrmd_pkg::REG_ON_LEVEL: cfg_on_lvl = val[16:0];
      hrmd_pkg::REG_OFF_LEVEL: cfg_off_lvl = val[16:0];
      hrmd_pkg::REG_MIN_ON: cfg_min_on = val;
      default: cfg_min_off = val;
    endcase
  endtask

  task automatic apply_settings(logic [16:0] on_l, logic [16:0] off_l,
                                logic [31:0] min_on, logic [31:0] min_off);
    wait_idle();
    write_reg(hrmd_pkg::REG_ON_LEVEL, {15'b0, on_l});
    write_reg(hrmd_pkg::REG_OFF_LEVEL, {15'b0, off_l});
    write_reg(hrmd_pkg::REG_MIN_ON, min_on);
    write_reg(hrmd_pkg::REG_MIN_OFF, min_off);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [17:0] level_near();
    logic [16:0] on_t;
    logic [16:0] off_t;
    int v;
    eff_levels(on_t, off_t);
    case ($urandom_range(0, 3))
      0: v = int'(on_t) + int'($urandom_range(0, 4)) - 2;
      1: v = int'(off_t) + int'($urandom_range(0, 4)) - 2;
      2: v = int'($urandom_range(0, 65536));
      default: v = int'($urandom);
    endcase
    return 18'(v);
  endfunction

  // One proposal, mostly followed by its commit, a resync, or a stray beat.
  task automatic send_episode();
    relay_evt_t ev;
    hrmd_pkg::res_t pr;
    int unsigned pick;
    int unsigned r;
    logic [1:0] ovr;
    logic [31:0] tag;
    if ($urandom_range(0, 99) < 3 && now_ms > 48'd200) now_ms = now_ms - $urandom_range(0, 200);
    else now_ms = now_ms + $urandom_range(0, 120);
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      r = $urandom_range(0, 99);
      ovr = (r < 80) ? hrmd_pkg::OVR_NONE :
            (r < 88) ? hrmd_pkg::OVR_ON :
            (r < 96) ? hrmd_pkg::OVR_OFF : OVR_UNDEF;
      do_propose(level_near(), $urandom_range(0, 19) == 0, ovr, now_ms, pr);
      if ($urandom_range(0, 9) != 0) begin
        tag = pr.current_generation;
        if ($urandom_range(0, 19) == 0) tag = tag + 32'd1;
        do_commit(pr.target_is_on, pr.command_needed, pr.dwell_hold, tag, now_ms,
                  $urandom_range(0, 99) < 85);
      end
    end else if (pick < 80) begin
      do_sync(1'($urandom), now_ms);
    end else begin
      ev = rand_evt();
      if ($urandom_range(0, 1) == 0) ev.time_ms = now_ms;
      send_item(ev, pr);
    end
  endtask

  task automatic test_directed_decisions();
    relay_evt_t ev;
    hrmd_pkg::res_t pr;
    apply_settings(17'h08000, 17'h04000, 32'd100, 32'd50);
    do_propose(18'h1FFFF, 1'b1, hrmd_pkg::OVR_NONE, 48'd10, pr);
    do_propose(18'h20000, 1'b0, hrmd_pkg::OVR_NONE, 48'd10, pr);
    do_propose(18'h1FFFF, 1'b0, hrmd_pkg::OVR_NONE, 48'd10, pr);
    do_commit(1'b1, 1'b1, 1'b0, pr.current_generation, 48'd1000, 1'b1);
    do_propose(18'h04000, 1'b0, hrmd_pkg::OVR_NONE, 48'd1050, pr);
    do_commit(pr.target_is_on, pr.command_needed, pr.dwell_hold, pr.current_generation,
              48'd1050, 1'b1);
    do_propose(18'h04001, 1'b0, hrmd_pkg::OVR_NONE, 48'd1100, pr);
    do_propose(18'h04000, 1'b0, hrmd_pkg::OVR_NONE, 48'd1100, pr);
    do_commit(1'b0, 1'b1, 1'b0, ~pr.current_generation, 48'd1100, 1'b1);
    do_commit(1'b0, 1'b1, 1'b0, pr.current_generation, 48'd1100, 1'b0);
    do_commit(1'b0, 1'b1, 1'b0, pr.current_generation, 48'd1100, 1'b1);
    do_propose(18'h08000, 1'b0, hrmd_pkg::OVR_NONE, 48'd900, pr);
    do_propose(18'h00000, 1'b0, hrmd_pkg::OVR_ON, 48'd900, pr);
    do_propose(18'h1FFFF, 1'b0, hrmd_pkg::OVR_OFF, 48'd900, pr);
    do_propose(18'h08000, 1'b0, OVR_UNDEF, 48'd1200, pr);
    ev = rand_evt();
    ev.func = FUNC_UNDEF;
    send_item(ev, pr);
    do_sync(1'b1, 48'hFFFF_FFFF_FFFF);
    do_propose(18'h00000, 1'b0, hrmd_pkg::OVR_NONE, 48'd0, pr);
    do_commit(1'b0, 1'b0, 1'b0, pr.current_generation, 48'd5, 1'b1);
    do_sync(1'b0, 48'd0);
  endtask

  task automatic test_threshold_extremes();
    hrmd_pkg::res_t pr;
    apply_settings(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_propose(18'h0FFFF, 1'b0, hrmd_pkg::OVR_NONE, 48'd5, pr);
    do_sync(1'b1, 48'd0);
    do_propose(18'h10000, 1'b0, hrmd_pkg::OVR_NONE, 48'h0000_FFFF_FFFE, pr);
    do_propose(18'h10000, 1'b0, hrmd_pkg::OVR_NONE, 48'hFFFF_FFFF_FFFF, pr);
    apply_settings(17'h00000, 17'h10000, 32'd0, 32'd0);
    do_propose(18'h00000, 1'b0, hrmd_pkg::OVR_NONE, 48'd7, pr);
    do_sync(1'b0, 48'd5);
    do_propose(18'h00000, 1'b0, hrmd_pkg::OVR_NONE, 48'd5, pr);
  endtask

  task automatic test_output_backpressure();
    apply_settings(17'h0C000, 17'h03000, 32'd40, 32'd30);
    tx_mode = 1'b0;
    fork
      begin
        @(posedge clk);
        out_hold = 1'b1;
        repeat (300) @(posedge clk);
        out_hold = 1'b0;
      end
      repeat (20) send_episode();
    join
    wait_idle();
    tx_mode = 1'b1;
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned next_cfg;
    logic [16:0] on_l;
    logic [16:0] off_l;
    logic [31:0] dwell[2];
    stop_at = items_sent + n_items;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        case ($urandom_range(0, 9))
          0: on_l = 17'h00000;
          1: on_l = hrmd_pkg::LEVEL_ONE;
          2: on_l = 17'h1FFFF;
          default: on_l = 17'($urandom_range(0, 65536));
        endcase
        if ($urandom_range(0, 99) < 15) off_l = 17'($urandom_range(on_l, 17'h1FFFF));
        else off_l = 17'($urandom_range(0, (on_l > hrmd_pkg::LEVEL_ONE) ?
                                             hrmd_pkg::LEVEL_ONE : on_l));
        foreach (dwell[i]) begin
          case ($urandom_range(0, 19))
            0, 1: dwell[i] = 32'd0;
            2: dwell[i] = 32'hFFFF_FFFF;
            default: dwell[i] = $urandom_range(0, 300);
          endcase
        end
        apply_settings(on_l, off_l, dwell[0], dwell[1]);
        tx_mode = $urandom_range(0, 3) != 0;
        rx_mode = $urandom_range(0, 3) != 0;
        next_cfg = items_sent + $urandom_range(40, 80);
      end
      send_episode();
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_decisions();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_traffic(790);
    repeat (8) @(posedge clk);
    $display("Run covered %0d events: %0d proposals, %0d commits, %0d syncs, %0d unknown codes.",
             items_sent, n_propose, n_commit, n_sync, n_undef);
    $display("It saw %0d dwell holds and %0d accepted commits over %0d register settings.",
             n_hold, n_accept, n_settings);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS hysteresis_relay_with_min_dwell");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", mismatch_count,
               pending_results.size());
      $display("FAIL hysteresis_relay_with_min_dwell");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/hrmd_pkg.sv
rtl/hrmd_cfg.sv
rtl/hrmd_core.sv
rtl/hysteresis_relay_with_min_dwell.sv
verif/tb_hysteresis_relay_with_min_dwell.sv
